// ===== design/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer: header
// positions, result kinds, opcodes, length codes and the result record.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Default width kept for the decoded payload length
  localparam int LengthBitsDef = 64;
  // Width of the reported frame length (bit 63 of the wire length is reserved)
  localparam int FrameLenW     = 63;
  // Bytes in the masking key
  localparam int KeyBytes      = 4;
  localparam int KeySelW       = $clog2(KeyBytes);

  // Opcodes with special handling
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Header position: which byte of the frame comes next
  typedef enum logic [3:0] {
    POS_FIRST   = 4'd0,
    POS_LEN     = 4'd1,
    POS_EXT0    = 4'd2,
    POS_EXT1    = 4'd3,
    POS_EXT2    = 4'd4,
    POS_EXT3    = 4'd5,
    POS_EXT4    = 4'd6,
    POS_EXT5    = 4'd7,
    POS_EXT6    = 4'd8,
    POS_EXT7    = 4'd9,
    POS_KEY0    = 4'd10,
    POS_KEY1    = 4'd11,
    POS_KEY2    = 4'd12,
    POS_KEY3    = 4'd13,
    POS_PAYLOAD = 4'd14
  } hdr_pos_e;

  // Kind of a result beat
  typedef enum logic [2:0] {
    KIND_APP       = 3'd0,
    KIND_PONG      = 3'd1,
    KIND_HDR_DONE  = 3'd2,
    KIND_CLOSE     = 3'd3,
    KIND_UNMASKED  = 3'd4
  } kind_e;

  // One result beat
  typedef struct packed {
    kind_e                kind;
    logic [7:0]           out_byte;
    logic [3:0]           opcode;
    logic [3:0]           flag_bits;
    logic [FrameLenW-1:0] frame_length;
    logic                 last_byte;
  } wsd_result_t;

endpackage

// ===== design/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Frame state and single-pass parse of one byte: header fields, extended
// length, masking key, payload unmasking and the header end event.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; #(
  parameter int LENGTH_BITS = LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        buffer_start_i,
  output logic        res_valid_o,
  output wsd_result_t res_o
);

  // Bit 63 of the wire length is reserved, so at most 63 bits are kept
  localparam int LenW = (LENGTH_BITS > FrameLenW) ? FrameLenW : LENGTH_BITS;

  hdr_pos_e             pos_q, pos_d;
  logic [3:0]           flag_q, flag_d;
  logic [3:0]           opcode_q, opcode_d;
  logic                 masked_q, masked_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [LenW-1:0]      rem_q, rem_d;
  logic [31:0]          key_q, key_d;
  logic [KeySelW-1:0]   idx_q, idx_d;
  logic                 drop_q, drop_d;

  hdr_pos_e             pos_cur;
  logic                 drop_cur;
  logic                 hdr_end;
  logic [LenW-1:0]      hdr_len;
  logic                 hdr_masked;
  logic [KeySelW-1:0]   key_sel;
  logic                 last;

  // Hold frame state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_FIRST;
      flag_q   <= '0;
      opcode_q <= '0;
      masked_q <= 1'b0;
      len_q    <= '0;
      rem_q    <= '0;
      key_q    <= '0;
      idx_q    <= '0;
      drop_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      flag_q   <= flag_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      drop_q   <= drop_d;
    end
  end

  // Parse one byte and form its result
  always_comb begin
    pos_d      = pos_q;
    flag_d     = flag_q;
    opcode_d   = opcode_q;
    masked_d   = masked_q;
    len_d      = len_q;
    rem_d      = rem_q;
    key_d      = key_q;
    idx_d      = idx_q;
    drop_d     = drop_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    hdr_end     = 1'b0;
    hdr_len     = len_q;
    hdr_masked  = masked_q;
    last        = (rem_q == LenW'(1));

    // A buffer start restarts header parsing and ends dropping
    pos_cur  = buffer_start_i ? POS_FIRST : pos_q;
    drop_cur = buffer_start_i ? 1'b0 : drop_q;
    key_sel  = KeySelW'(pos_cur - POS_KEY0);

    if (fire_i) begin
      pos_d  = pos_cur;
      drop_d = drop_cur;
      if (!drop_cur) begin
        unique case (pos_cur)
          POS_LEN: begin
            masked_d = rx_byte_i[7];
            len_d    = '0;
            if (rx_byte_i[6:0] == LEN_CODE_EXT16) begin
              pos_d = POS_EXT6;
            end else if (rx_byte_i[6:0] == LEN_CODE_EXT64) begin
              pos_d = POS_EXT0;
            end else begin
              len_d = LenW'(rx_byte_i[6:0]);
              if (!rx_byte_i[7]) begin
                hdr_end    = 1'b1;
                hdr_len    = LenW'(rx_byte_i[6:0]);
                hdr_masked = 1'b0;
              end else begin
                pos_d = POS_KEY0;
              end
            end
          end
          POS_EXT0, POS_EXT1, POS_EXT2, POS_EXT3,
          POS_EXT4, POS_EXT5, POS_EXT6, POS_EXT7: begin
            // Shift in the extended length, network byte order
            len_d = {len_q[LenW-9:0], rx_byte_i};
            pos_d = hdr_pos_e'(4'(pos_cur + 4'd1));
            if (pos_cur == POS_EXT7 && !masked_q) begin
              hdr_end = 1'b1;
              hdr_len = {len_q[LenW-9:0], rx_byte_i};
            end
          end
          POS_KEY0, POS_KEY1, POS_KEY2, POS_KEY3: begin
            key_d[8*key_sel +: 8] = rx_byte_i;
            pos_d = hdr_pos_e'(4'(pos_cur + 4'd1));
            hdr_end = (pos_cur == POS_KEY3);
          end
          POS_PAYLOAD: begin
            // Unmask with the key bytes in turn
            res_valid_o        = 1'b1;
            res_o.kind         = (opcode_q == OP_PING) ? KIND_PONG : KIND_APP;
            res_o.out_byte     = rx_byte_i ^ key_q[8*idx_q +: 8];
            res_o.opcode       = opcode_q;
            res_o.flag_bits    = flag_q;
            res_o.frame_length = FrameLenW'(len_q);
            res_o.last_byte    = last;
            rem_d              = rem_q - LenW'(1);
            if (last) begin
              pos_d = POS_FIRST;
              idx_d = '0;
            end else begin
              idx_d = idx_q + KeySelW'(1);
            end
          end
          default: begin
            // First header byte; the unused position code acts the same
            flag_d   = rx_byte_i[7:4];
            opcode_d = rx_byte_i[3:0];
            masked_d = 1'b0;
            len_d    = '0;
            key_d    = '0;
            idx_d    = '0;
            pos_d    = POS_LEN;
          end
        endcase

        // Report the header end and arm the payload, if any; unmasked and close frames are dropped
        if (hdr_end) begin
          idx_d              = '0;
          rem_d              = hdr_len;
          pos_d              = (hdr_len == '0) ? POS_FIRST : POS_PAYLOAD;
          res_valid_o        = 1'b1;
          res_o.opcode       = opcode_q;
          res_o.flag_bits    = flag_q;
          res_o.frame_length = FrameLenW'(hdr_len);
          if (!hdr_masked) begin
            res_o.kind = KIND_UNMASKED;
            drop_d     = 1'b1;
          end else if (opcode_q == OP_CLOSE) begin
            res_o.kind = KIND_CLOSE;
            drop_d     = 1'b1;
          end else begin
            res_o.kind = KIND_HDR_DONE;
          end
        end
      end
    end
  end

endmodule

// ===== design/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser with payload unmasking, one stream
// byte per beat.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------
//   in      | input     | in_valid_i/in_ready_o  | rx_byte_i, buffer_start_i
//   out     | output    | out_valid_o/out_ready_i| kind_o, out_byte_o,
//           |           |                        | opcode_o, flag_bits_o,
//           |           |                        | frame_length_o, last_byte_o
//
// One byte per cycle while the result register is not stalled; a byte's beat
// passes the input register, then is parsed into the result register, from
// which it can be taken.
// Header bytes other than the last one, and dropped bytes, give no beat.
// A stalled result register holds the byte in the input register; a new
// byte is taken while the input register is empty or moving on.
// Reset clears the frame state to expect a first header byte.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int LENGTH_BITS = LengthBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 buffer_start_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           kind_o,
  output logic [7:0]           out_byte_o,
  output logic [3:0]           opcode_o,
  output logic [3:0]           flag_bits_o,
  output logic [FrameLenW-1:0] frame_length_o,
  output logic                 last_byte_o
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_start_q;
  logic        advance;
  logic        fire;
  logic        res_valid;
  wsd_result_t res;
  logic        out_valid_q;
  wsd_result_t out_q;

  // Move on when the result register is free or being taken
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q  <= rx_byte_i;
      in_start_q <= buffer_start_i;
    end
  end

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .rx_byte_i      (in_byte_q),
    .buffer_start_i (in_start_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign out_byte_o     = out_q.out_byte;
  assign opcode_o       = out_q.opcode;
  assign flag_bits_o    = out_q.flag_bits;
  assign frame_length_o = out_q.frame_length;
  assign last_byte_o    = out_q.last_byte;

  // Input side stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while result register free");

  // A new result beat comes only from a byte held in the input register
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q))
    else $error("result beat without a parsed byte");

  // Last-byte flag only on payload beats
  a_last_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_byte_o) |-> (kind_o == KIND_APP || kind_o == KIND_PONG))
    else $error("last byte flag on a header event");

  // Header events carry a zero data byte
  a_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_APP && kind_o != KIND_PONG) |-> (out_byte_o == 8'd0))
    else $error("header event with nonzero data byte");

endmodule
